FILE: rtl/gfr_pkg.sv
// Shared constants, types and glyph tables of the glyph framebuffer renderer.
package gfr_pkg;

   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_W       = $clog2(STORE_BYTES);
   localparam int QUEUE_DEPTH  = 2;
   localparam int LARGE_LAST   = 4;
   localparam int SMALL_LAST   = 3;
   localparam int SMALL_SCALE  = 2;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LARGE = 2'd1;
   localparam logic [1:0] ACT_SMALL = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   typedef struct packed {
      logic            known;
      logic [4:0][7:0] cols;
   } glyph_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [7:0]        origin_x;
      logic [7:0]        origin_y;
      logic [4:0][7:0]   cols;
      logic [2:0]        col_last;
      logic [3:0]        scale;
      logic              known;
      logic [ADDR_W-1:0] read_addr;
      logic              read_ok;
   } gfr_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } gfr_queue_status_type;

   function automatic glyph_type large_glyph(input logic [7:0] code);
      glyph_type g;
      g.known = 1'b1;
      case (code)
         8'h30: g.cols = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
         8'h31: g.cols = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
         8'h32: g.cols = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
         8'h33: g.cols = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
         8'h34: g.cols = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
         8'h35: g.cols = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         8'h36: g.cols = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         8'h37: g.cols = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         8'h38: g.cols = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h39: g.cols = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         8'h2E: g.cols = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
         8'h43: g.cols = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
         default: begin
            g.known = 1'b0;
            g.cols  = '0;
         end
      endcase
      return g;
   endfunction

   function automatic glyph_type small_glyph(input logic [7:0] code);
      glyph_type g;
      g.known = 1'b1;
      case (code)
         8'h54: g.cols = {8'h00, 8'h01, 8'h7F, 8'h01, 8'h01};
         8'h45: g.cols = {8'h00, 8'h41, 8'h49, 8'h49, 8'h7F};
         8'h4D: g.cols = {8'h00, 8'h7F, 8'h06, 8'h06, 8'h7F};
         8'h50: g.cols = {8'h00, 8'h06, 8'h09, 8'h09, 8'h7F};
         8'h41: g.cols = {8'h00, 8'h7E, 8'h09, 8'h09, 8'h7E};
         8'h52: g.cols = {8'h00, 8'h46, 8'h19, 8'h09, 8'h7F};
         8'h55: g.cols = {8'h00, 8'h3F, 8'h40, 8'h40, 8'h3F};
         default: begin
            g.known = 1'b0;
            g.cols  = '0;
         end
      endcase
      return g;
   endfunction

endpackage

FILE: rtl/gfr_front.sv
// Front end: decodes an incoming transaction into a work entry.
module gfr_front (
   input  logic                  req_tvalid,
   input  logic [39:0]           req_tdata,
   input  logic                  queue_ready,
   output logic                  push,
   output gfr_pkg::gfr_entry_type entry
);
   import gfr_pkg::*;

   logic [1:0] action;
   logic [7:0] code;
   logic [3:0] zoom;
   logic [2:0] page;
   logic [6:0] column;
   glyph_type  g_large;
   glyph_type  g_small;

   assign action = req_tdata[1:0];
   assign code   = req_tdata[25:18];
   assign zoom   = req_tdata[29:26];
   assign page   = req_tdata[32:30];
   assign column = req_tdata[39:33];
   assign g_large = large_glyph(code);
   assign g_small = small_glyph(code);
   assign push    = req_tvalid & queue_ready;

   always_comb begin
      entry.action    = action;
      entry.origin_x  = req_tdata[9:2];
      entry.origin_y  = req_tdata[17:10];
      entry.read_addr = ADDR_W'(int'(column) + int'(page) * PANEL_WIDTH);
      entry.read_ok   = (int'(column) < PANEL_WIDTH) && (int'(page) < PAGE_COUNT);
      case (action)
         ACT_LARGE: begin
            entry.cols     = g_large.cols;
            entry.known    = g_large.known;
            entry.col_last = 3'(LARGE_LAST);
            entry.scale    = zoom;
         end
         ACT_SMALL: begin
            entry.cols     = g_small.cols;
            entry.known    = g_small.known;
            entry.col_last = 3'(SMALL_LAST);
            entry.scale    = 4'(SMALL_SCALE);
         end
         default: begin
            entry.cols     = '0;
            entry.known    = 1'b0;
            entry.col_last = '0;
            entry.scale    = '0;
         end
      endcase
   end
endmodule

FILE: rtl/gfr_queue.sv
// Small queue of decoded work entries between front and back end.
module gfr_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  gfr_pkg::gfr_entry_type       push_entry,
   input  logic                         pop,
   output gfr_pkg::gfr_entry_type       head,
   output gfr_pkg::gfr_queue_status_type status
);
   import gfr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   gfr_entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop) else $error("queue pop while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance");
`endif
endmodule

FILE: rtl/gfr_back.sv
// Back end: framebuffer memory and the clear, draw and read sequencer.
module gfr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  gfr_pkg::gfr_entry_type head,
   input  logic                   queue_empty,
   output logic                   pop,
   output logic                   init_busy,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata
);
   import gfr_pkg::*;

   typedef enum logic [9:0] {
      S_INIT  = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_CLEAR = 10'b0000000100,
      S_COL   = 10'b0000001000,
      S_ROW   = 10'b0000010000,
      S_RDM   = 10'b0000100000,
      S_WRM   = 10'b0001000000,
      S_RDA   = 10'b0010000000,
      S_RDB   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   gfr_entry_type     job_ff, job_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [2:0]        c_ff, c_in;
   logic [3:0]        dx_ff, dx_in;
   logic [2:0]        r_ff, r_in;
   logic [3:0]        dy_ff, dy_in;
   logic [7:0]        x_ff, x_in;
   logic [7:0]        y_ff, y_in;
   logic [7:0]        mask_ff, mask_in;
   logic              last_ff, last_in;
   logic [7:0]        res_data_ff, res_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_known_ff, rsp_known_in;

   logic [7:0]        pixel_mem_ff [STORE_BYTES];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [7:0]        mem_wdata;

   logic [7:0]        cur_col;
   logic              col_end;
   logic              glyph_end;
   logic              row_last;
   logic              page_end;
   logic [7:0]        mask_next;
   logic              out_free;

   assign cur_col   = job_ff.cols[c_ff];
   assign col_end   = (dx_ff == job_ff.scale - 1'b1);
   assign glyph_end = col_end && (c_ff == job_ff.col_last);
   assign row_last  = (r_ff == 3'd6) && (dy_ff == job_ff.scale - 1'b1);
   assign page_end  = (y_ff[2:0] == 3'd7) || row_last;
   assign mask_next = mask_ff |
      (((cur_col[r_ff] && (int'(y_ff) < PANEL_HEIGHT)) ? 8'd1 : 8'd0) << y_ff[2:0]);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign init_busy = (state_ff == S_INIT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_known_ff, rsp_data_ff};

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      addr_in      = addr_ff;
      c_in         = c_ff;
      dx_in        = dx_ff;
      r_in         = r_ff;
      dy_in        = dy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      mask_in      = mask_ff;
      last_in      = last_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_known_in = rsp_known_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = 8'd0;
      case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == ADDR_W'(STORE_BYTES - 1)) begin
               addr_in  = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (!queue_empty) begin
               pop         = 1'b1;
               job_in      = head;
               res_data_in = 8'd0;
               addr_in     = '0;
               c_in        = '0;
               dx_in       = '0;
               x_in        = head.origin_x;
               case (head.action)
                  ACT_CLEAR: state_in = S_CLEAR;
                  ACT_READ: begin
                     addr_in  = head.read_addr;
                     state_in = head.read_ok ? S_RDA : S_DONE;
                  end
                  default: begin
                     state_in = (head.known && head.scale != '0) ? S_COL : S_DONE;
                  end
               endcase
            end
         end
         S_COL: begin
            if ((int'(x_ff) < PANEL_WIDTH) && (cur_col != 8'd0)) begin
               r_in     = '0;
               dy_in    = '0;
               y_in     = job_ff.origin_y;
               mask_in  = 8'd0;
               state_in = S_ROW;
            end else begin
               x_in  = x_ff + 1'b1;
               dx_in = col_end ? '0 : dx_ff + 1'b1;
               c_in  = col_end ? c_ff + 1'b1 : c_ff;
               state_in = glyph_end ? S_DONE : S_COL;
            end
         end
         S_ROW: begin
            y_in    = y_ff + 1'b1;
            dy_in   = (dy_ff == job_ff.scale - 1'b1) ? '0 : dy_ff + 1'b1;
            r_in    = (dy_ff == job_ff.scale - 1'b1) ? r_ff + 1'b1 : r_ff;
            mask_in = mask_next;
            if (page_end) begin
               last_in = row_last;
               addr_in = ADDR_W'(int'(x_ff) + int'(y_ff[7:3]) * PANEL_WIDTH);
               if (mask_next != 8'd0) begin
                  state_in = S_RDM;
               end else if (row_last) begin
                  x_in  = x_ff + 1'b1;
                  dx_in = col_end ? '0 : dx_ff + 1'b1;
                  c_in  = col_end ? c_ff + 1'b1 : c_ff;
                  state_in = glyph_end ? S_DONE : S_COL;
               end
            end
         end
         S_RDM: state_in = S_WRM;
         S_WRM: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff | mask_ff;
            mask_in   = 8'd0;
            if (last_ff) begin
               x_in  = x_ff + 1'b1;
               dx_in = col_end ? '0 : dx_ff + 1'b1;
               c_in  = col_end ? c_ff + 1'b1 : c_ff;
               state_in = glyph_end ? S_DONE : S_COL;
            end else begin
               state_in = S_ROW;
            end
         end
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            res_data_in = rd_data_ff;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_known_in = job_ff.known;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      c_ff         <= c_in;
      dx_ff        <= dx_in;
      r_ff         <= r_in;
      dy_ff        <= dy_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      mask_ff      <= mask_in;
      last_ff      <= last_in;
      res_data_ff  <= res_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_known_ff <= rsp_known_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem_ff[addr_ff] <= mem_wdata;
      end
      rd_data_ff <= pixel_mem_ff[addr_ff];
   end

`ifndef ASSERT_OFF
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_INIT || state_ff == S_CLEAR || state_ff == S_WRM))
      else $error("memory write outside a write state");
   a_rmw_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRM) |-> (mask_ff != 8'd0)) else $error("empty merge mask");
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRM) |-> ($past(state_ff) == S_RDM))
      else $error("merge write without prior read");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending transaction dropped");
`endif
endmodule

FILE: rtl/glyph_framebuffer_renderer_unit.sv
// Top level of the glyph framebuffer renderer.
// A 128x64 monochrome framebuffer in 8-row pages (one byte per column per page,
// bit 0 at the top) with a small glyph generator. Each request transaction
// clears the store, ORs in a scaled 5x7 large glyph or a 2x-scaled 4x7 compact
// glyph, or reads one byte; every request returns exactly one response. After
// reset the store is wiped by a clearing pass over all 1024 bytes during which
// req_tready stays low. A clear writes every byte of the store in turn, and a
// read fetches the addressed byte into the response. A draw is carried out by
// the sequencer, which steps through each scaled glyph column and, for a
// visible non-blank one, walks the scaled glyph one pixel row per cycle,
// pausing for a memory read-modify-write of each touched page byte. A 2-entry
// queue lets new requests be accepted while one is being carried out, and the
// response register holds a finished result while the next request is worked
// on.
module glyph_framebuffer_renderer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0], origin_x[9:2], origin_y[17:10], char_code[25:18],
   // zoom[29:26], read_page[32:30], read_column[39:33]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], glyph_known[8], zero fill [15:9]
   output logic [15:0] rsp_tdata
);
   import gfr_pkg::*;

   gfr_entry_type        push_entry;
   gfr_entry_type        head;
   gfr_queue_status_type qstat;
   logic                 push;
   logic                 pop;
   logic                 init_busy;
   logic                 queue_ready;

   // hold off requests while the queue is full or the startup wipe runs
   assign queue_ready = !qstat.full && !init_busy;
   assign req_tready  = queue_ready;

   gfr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .queue_ready(queue_ready),
      .push       (push),
      .entry      (push_entry)
   );

   gfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .status    (qstat)
   );

   gfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .queue_empty(qstat.empty),
      .pop        (pop),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
